FILE: hw/rtl/swfc_pkg.sv
// Shared types, constants and helpers for the sorted word frequency counter.
package swfc_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int MAX_LETTERS = 31;
	localparam int COUNT_WIDTH = 32;
	localparam int ROW_SLOTS   = 31;
	localparam int KEY_W       = ROW_SLOTS * 5;
	localparam int LEN_W       = 5;
	localparam int TOT_W       = $clog2(TABLE_DEPTH + 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_TEXT = 2'd0,
		OP_END  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_COUNTED  = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_READ     = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_NOWORD   = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] char_code;
		logic [7:0] entry_index;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [59:0] word_part0;
		logic [59:0] word_part1;
		logic [34:0] word_part2;
		logic [4:0]  word_length;
		logic [31:0] word_count;
		logic [7:0]  sorted_position;
		logic [8:0]  distinct_words;
	} out_t;

	// One table entry as held by a cell
	typedef struct packed {
		logic                   vld;
		logic [KEY_W-1:0]       word;
		logic [LEN_W-1:0]       len;
		logic [COUNT_WIDTH-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic inc;
	} cell_ctrl_t;

	// Map a byte to a letter code a=1..z=26, 0 for anything else
	function automatic logic [4:0] letter_code(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h61 && c <= 8'h7a)
			d = c - 8'h60;
		else if (c >= 8'h41 && c <= 8'h5a)
			d = c - 8'h40;
		return d[4:0];
	endfunction

endpackage

FILE: hw/rtl/swfc_cell.sv
// One cell of the sorted table chain: holds one entry, compares, shifts.
module swfc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  swfc_pkg::cell_ctrl_t      ctrl,
	input  logic [swfc_pkg::KEY_W-1:0] key_word,
	input  logic [swfc_pkg::LEN_W-1:0] key_len,
	input  swfc_pkg::entry_t          left,
	input  logic                      left_ge,
	input  logic                      sel,
	output swfc_pkg::entry_t          entry,
	output logic                      ge,
	output logic                      lt_s1,
	output logic                      eq_s1,
	output swfc_pkg::entry_t          rep
);
	import swfc_pkg::*;

	logic                   vld_q;
	logic [KEY_W-1:0]       word_q;
	logic [LEN_W-1:0]       len_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	assign entry = '{vld: vld_q, word: word_q, len: len_q, cnt: cnt_q};
	// entry sorts after the key, or slot is free
	assign ge    = !lt_s1 && !eq_s1;
	assign rep   = (sel && vld_q) ? entry : '0;

	// Compare flags against the broadcast key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_s1 <= 1'b0;
			eq_s1 <= 1'b0;
		end else if (ctrl.cmp) begin
			lt_s1 <= vld_q && (word_q < key_word);
			eq_s1 <= vld_q && (word_q == key_word);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.ins && left_ge) begin
			vld_q <= left.vld;
		end else if (ctrl.ins && ge) begin
			vld_q <= 1'b1;
		end
	end

	// Shift right from the neighbor, take the new word, or bump the count
	always_ff @(posedge clk) begin
		if (ctrl.ins && left_ge) begin
			word_q <= left.word;
			len_q  <= left.len;
			cnt_q  <= left.cnt;
		end else if (ctrl.ins && ge) begin
			word_q <= key_word;
			len_q  <= key_len;
			cnt_q  <= COUNT_WIDTH'(1);
		end else if (ctrl.inc && eq_s1 && cnt_q != COUNT_MAX) begin
			cnt_q  <= cnt_q + COUNT_WIDTH'(1);
		end
	end

endmodule

FILE: hw/rtl/sorted_word_frequency_counter.sv
// Top level of the sorted word frequency counter.
// Text bytes are taken one per cycle while in_stall is low, and a letter is added to the pending word at once.
// A finished word is accepted in S_IDLE; in S_CMP every cell compares the
// word against its entry, and in S_WR the word is counted or inserted (shifting the cell chain)
// and the result is registered. Reads and the end of text with no pending word register their
// result at the accepting edge. The table is a chain of TABLE_DEPTH cells held in
// flip-flops.
module sorted_word_frequency_counter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  swfc_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output swfc_pkg::out_t out_data
);
	import swfc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_WR
	} state_t;

	state_t           state_q;
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] klen_q;
	logic [TOT_W-1:0] total_q;
	out_t             out_q;
	logic             out_valid_q;

	cell_ctrl_t       ctrl;
	entry_t           ent   [TABLE_DEPTH];
	entry_t           rep   [TABLE_DEPTH];
	logic             ge    [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] lt_v;
	logic [TABLE_DEPTH-1:0] eq_v;
	logic [TABLE_DEPTH-1:0] sel_v;
	entry_t           rep_or;
	logic [TOT_W-1:0] pos;
	logic             acc;
	logic             res_load;
	logic [4:0]       code;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign acc       = in_valid && !in_stall;
	assign code      = letter_code(in_data.char_code);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A result is loaded by a finished lookup, a read, or an end with no pending word
	assign res_load = (state_q == S_WR) || (acc && ((in_data.opcode == OP_READ) ||
		((in_data.opcode == OP_END) && (klen_q == '0))));

	assign ctrl.cmp = (state_q == S_CMP);
	assign ctrl.inc = (state_q == S_WR) && (|eq_v);
	assign ctrl.ins = (state_q == S_WR) && !(|eq_v) && (total_q < TOT_W'(TABLE_DEPTH));

	// Cell chain
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign sel_v[i] = (state_q == S_WR) ? eq_v[i] : (int'(in_data.entry_index) == i);
		if (i == 0) begin : g_head
			swfc_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .key_word(key_q), .key_len(klen_q),
				.left('0), .left_ge(1'b0), .sel(sel_v[i]), .entry(ent[i]), .ge(ge[i]),
				.lt_s1(lt_v[i]), .eq_s1(eq_v[i]), .rep(rep[i])
			);
		end else begin : g_body
			swfc_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .key_word(key_q), .key_len(klen_q),
				.left(ent[i-1]), .left_ge(ge[i-1]), .sel(sel_v[i]), .entry(ent[i]),
				.ge(ge[i]), .lt_s1(lt_v[i]), .eq_s1(eq_v[i]), .rep(rep[i])
			);
		end
	end

	// Gather the selected entry and the sorted boundary
	always_comb begin
		rep_or = '0;
		pos    = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			rep_or = rep_or | rep[i];
			if (!lt_v[i] && (i == 0 || lt_v[(i == 0) ? 0 : i-1]))
				pos = pos | TOT_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_q       <= '0;
			klen_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// Raise valid on a new result, drop it once the result is taken
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (opcode_t'(in_data.opcode))
							OP_TEXT: begin
								if (code != 5'd0) begin
									// append, dropping letters past the limit
									if (klen_q < LEN_W'(MAX_LETTERS)) begin
										for (int s = 0; s < ROW_SLOTS; s++)
											if (LEN_W'(s) == klen_q)
												key_q[KEY_W-1-5*s -: 5] <= code;
										klen_q <= klen_q + LEN_W'(1);
									end
								end else if (klen_q != '0) begin
									state_q <= S_CMP;
								end
							end
							OP_END: begin
								if (klen_q != '0) begin
									state_q <= S_CMP;
								end else begin
									out_q <= '{status: ST_NOWORD,
										distinct_words: 9'(total_q), default: '0};
								end
							end
							OP_READ: begin
								// an unused slot gathers as all zero
								out_q <= '{
									status:          (rep_or.vld ? ST_READ : ST_EMPTY),
									word_part0:      rep_or.word[154:95],
									word_part1:      rep_or.word[94:35],
									word_part2:      rep_or.word[34:0],
									word_length:     rep_or.len,
									word_count:      32'(rep_or.cnt),
									sorted_position: in_data.entry_index,
									distinct_words:  9'(total_q)
								};
							end
							default: begin
							end
						endcase
					end
				end
				S_CMP: begin
					state_q <= S_WR;
				end
				S_WR: begin
					out_q.word_part0      <= key_q[154:95];
					out_q.word_part1      <= key_q[94:35];
					out_q.word_part2      <= key_q[34:0];
					out_q.word_length     <= klen_q;
					out_q.sorted_position <= pos[7:0];
					if (|eq_v) begin
						out_q.status         <= ST_COUNTED;
						out_q.word_count     <= 32'((rep_or.cnt == COUNT_MAX) ? rep_or.cnt
							: rep_or.cnt + COUNT_WIDTH'(1));
						out_q.distinct_words <= 9'(total_q);
					end else if (total_q < TOT_W'(TABLE_DEPTH)) begin
						out_q.status         <= ST_INSERTED;
						out_q.word_count     <= 32'd1;
						out_q.distinct_words <= 9'(total_q + TOT_W'(1));
						total_q              <= total_q + TOT_W'(1);
					end else begin
						out_q.status         <= ST_FULL;
						out_q.word_count     <= 32'd0;
						out_q.distinct_words <= 9'(total_q);
					end
					key_q       <= '0;
					klen_q      <= '0;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// a word matches at most one entry
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> $onehot0(eq_v))
		else $error("several entries match one word");
	// the result slot is free when a lookup finishes
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WR |-> !out_valid_q)
		else $error("result overwritten");
	// the table never grows past its depth
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_W'(TABLE_DEPTH))
		else $error("entry total overflow");
	// a lookup always follows a compare cycle
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |=> state_q == S_WR)
		else $error("compare not followed by update");
`endif

endmodule

FILE: test/tb_sorted_word_frequency_counter.sv
// Testbench for the sorted word frequency counter: random text against a table tracker.
module tb_sorted_word_frequency_counter;
	import swfc_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	// Track the sorted word table and queue the results each word should give
	class word_table_tracker;
		logic [4:0]   pend [ROW_SLOTS];
		int           pend_len;
		logic [154:0] tkey [TABLE_DEPTH];
		logic [31:0]  tcnt [TABLE_DEPTH];
		int           total;
		out_t         expected_words [$];
		int           errors;

		function new();
			foreach (pend[i]) pend[i] = 5'd0;
			pend_len = 0;
			total = 0;
			errors = 0;
		endfunction

		function automatic out_t make_result(status_t st, logic [154:0] key, int len,
				logic [31:0] cnt, int pos);
			out_t r;
			r.status          = st;
			r.word_part0      = key[154:95];
			r.word_part1      = key[94:35];
			r.word_part2      = key[34:0];
			r.word_length     = len[4:0];
			r.word_count      = cnt;
			r.sorted_position = pos[7:0];
			r.distinct_words  = total[8:0];
			return r;
		endfunction

		function automatic int key_length(logic [154:0] key);
			int n;
			n = 0;
			while (n < ROW_SLOTS && key[154 - 5*n -: 5] != 5'd0)
				n++;
			return n;
		endfunction

		// Look up the pending word, then count, insert or drop it
		function automatic void finish_word();
			logic [154:0] key;
			int pos;
			key = '0;
			for (int i = 0; i < ROW_SLOTS; i++)
				key = {key[149:0], pend[i]};
			foreach (pend[i]) pend[i] = 5'd0;
			pend_len = 0;
			pos = 0;
			while (pos < total && key > tkey[pos])
				pos++;
			if (pos < total && key == tkey[pos]) begin
				if (tcnt[pos] != 32'hffff_ffff)
					tcnt[pos]++;
				expected_words.push_back(make_result(ST_COUNTED, key, key_length(key),
					tcnt[pos], pos));
			end else if (total >= TABLE_DEPTH) begin
				expected_words.push_back(make_result(ST_FULL, key, key_length(key),
					32'd0, pos));
			end else begin
				for (int i = total; i > pos; i--) begin
					tkey[i] = tkey[i-1];
					tcnt[i] = tcnt[i-1];
				end
				tkey[pos] = key;
				tcnt[pos] = 32'd1;
				total++;
				expected_words.push_back(make_result(ST_INSERTED, key, key_length(key),
					32'd1, pos));
			end
		endfunction

		function automatic void note(in_t w);
			logic [4:0] code;
			code = letter_code(w.char_code);
			case (w.opcode)
				OP_TEXT: begin
					if (code != 5'd0) begin
						if (pend_len < MAX_LETTERS) begin
							pend[pend_len] = code;
							pend_len++;
						end
					end else if (pend_len != 0) begin
						finish_word();
					end
				end
				OP_END: begin
					if (pend_len == 0)
						expected_words.push_back(make_result(ST_NOWORD, '0, 0, 32'd0, 0));
					else
						finish_word();
				end
				OP_READ: begin
					if (w.entry_index < total)
						expected_words.push_back(make_result(ST_READ, tkey[w.entry_index],
							key_length(tkey[w.entry_index]), tcnt[w.entry_index],
							w.entry_index));
					else
						expected_words.push_back(make_result(ST_EMPTY, '0, 0, 32'd0,
							w.entry_index));
				end
				default: begin
				end
			endcase
		endfunction

		function automatic void check(out_t got);
			out_t exp;
			if (expected_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word result: %p", got);
				return;
			end
			exp = expected_words.pop_front();
			if (got.status != exp.status || got.word_part0 != exp.word_part0 ||
					got.word_part1 != exp.word_part1 || got.word_part2 != exp.word_part2 ||
					got.word_length != exp.word_length || got.word_count != exp.word_count ||
					got.sorted_position != exp.sorted_position ||
					got.distinct_words != exp.distinct_words) begin
				errors++;
				if (errors <= 10) begin
					$display("word result mismatch");
					$display("  expected %p", exp);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t  in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	word_table_tracker tracker;
	bit calm;
	int idle_cycles;
	int stall_left;
	int sent;

	sorted_word_frequency_counter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic bit is_letter(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	// Note accepted words, check results, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note(in_data);
			if (out_valid && !out_stall)
				tracker.check(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_sorted_word_frequency_counter: FAIL");
				$finish;
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = pick_gap();
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Present one word and hold it until taken
	task automatic send(input opcode_t op, input logic [7:0] c, input logic [7:0] idx);
		int g;
		in_data  <= '{opcode: op, char_code: c, entry_index: idx};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
		@(negedge clk);
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic send_letters(input int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
			send(OP_TEXT, c, 8'($urandom));
		end
	endtask

	task automatic send_separator();
		logic [7:0] c;
		c = 8'($urandom);
		while (is_letter(c))
			c = 8'($urandom);
		send(OP_TEXT, c, 8'($urandom));
	endtask

	// One random word with a random ending, or a read, end or noise item
	task automatic send_random_item();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			n = $urandom_range(0, 99);
			if (n < 80)
				n = $urandom_range(1, 3);
			else if (n < 97)
				n = $urandom_range(4, 9);
			else
				n = $urandom_range(28, 34);
			send_letters(n);
			if ($urandom_range(0, 9) == 0)
				send(OP_END, 8'($urandom), 8'($urandom));
			else
				send_separator();
		end else if (r < 85) begin
			send(OP_READ, 8'($urandom), 8'($urandom_range(0, 255)));
		end else if (r < 90) begin
			send(OP_END, 8'($urandom), 8'($urandom));
		end else if (r < 95) begin
			send(OP_TEXT, 8'($urandom), 8'($urandom));
		end else begin
			send(OP_NONE, 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		tracker     = new();
		calm        = 1'b0;
		idle_cycles = 0;
		stall_left  = 0;
		sent        = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_stall   = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, boundary bytes, prefixes, long word, ignored opcode
		send(OP_END, 8'h00, 8'h00);
		send(OP_READ, 8'h00, 8'h00);
		send(OP_READ, 8'hff, 8'hff);
		send(OP_TEXT, 8'h41, 8'h00);
		send(OP_TEXT, 8'h7a, 8'h00);
		send(OP_TEXT, 8'h40, 8'h00);
		send(OP_TEXT, 8'h61, 8'h00);
		send(OP_TEXT, 8'h5b, 8'h00);
		send(OP_TEXT, 8'h5a, 8'h00);
		send(OP_TEXT, 8'h60, 8'h00);
		send(OP_TEXT, 8'h7b, 8'h00);
		send(OP_TEXT, 8'h61, 8'h00);
		send(OP_TEXT, 8'h5a, 8'h00);
		send(OP_END, 8'hff, 8'h00);
		send(OP_NONE, 8'h61, 8'h00);
		send(OP_TEXT, 8'hff, 8'h00);
		send_letters(33);
		send(OP_END, 8'h00, 8'h00);
		send(OP_READ, 8'h00, 8'h00);
		send(OP_READ, 8'h00, 8'h01);
		send(OP_READ, 8'h00, 8'h03);

		// Random text, in stretches with idle gaps and occasional calm stretches
		while (sent < 550) begin
			calm = ($urandom_range(0, 7) == 0);
			repeat (5) send_random_item();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (tracker.expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_words.size() == 0)
			$display("tb_sorted_word_frequency_counter: PASS");
		else
			$display("tb_sorted_word_frequency_counter: FAIL");
		$finish;
	end

endmodule
